// File: rtl/rnd_pkg.sv
// shared types, constants and helpers for the radix-n digit converter
package rnd_pkg;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_A    = 7'h41;
  localparam logic [6:0] CHAR_F    = 7'h46;

  // word index of the radix register
  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_LD
  } conv_state_t;

  function automatic logic [6:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end else begin
      e = r;
    end
    return e;
  endfunction

endpackage

// File: rtl/rnd_ram.sv
// generic single-write, single-read ram with registered read data
module rnd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/radix_n_digit_converter.sv
// radix_n_digit_converter: binary integer to radix-n ascii digits, most significant first
//
// in channel: in_valid / in_stall with value; a beat is taken when in_valid is
// high and in_stall low. in_stall stays high from the accepted beat until the
// last digit of that value has moved into the output register.
// out channel: out_valid / out_stall with digit_char and last_digit; one beat per
// digit, the minimal number of digits, a zero input giving the single digit '0';
// last_digit marks the least significant digit.
// apb port: radix at byte address 0 (2 to 16, values outside are clamped), reset 10.
// each digit comes from a bit-serial restoring divider (one quotient bit per cycle),
// which writes the digits least significant first into the digit ram; the digits
// are then read from the ram in reverse and loaded into the output register.
// the next value is taken as soon as the last digit sits in the output register.
// a stalled receiver holds the output register and freezes the readout.
// reset (rst, synchronous) empties the output register, returns to idle and sets
// radix to 10; the digit ram is not cleared.
module radix_n_digit_converter
  import rnd_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            digit_char,
  output logic                  last_digit
);

  localparam int DEPTH = VALUE_BITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

  conv_state_t state, state_next;

  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    eff_radix;
  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W-1:0]    rem;
  logic [CW-1:0]         bitcnt;
  logic                  qnz;
  logic [AW-1:0]         idx;

  logic [RADIX_W-1:0]    rem_shift;
  logic                  qbit;
  logic [DIGIT_W-1:0]    rem_next;
  logic                  qnz_next;
  logic                  digit_done;

  logic                  in_accept;
  logic                  load;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    ram_rdata;
  logic                  cfg_write;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write && paddr[2] == REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RADIX) begin
      prdata = {{(32-RADIX_W){1'b0}}, radix};
    end
  end

  assign eff_radix = clamp_radix(radix);

  // ---------------------------------------------------------------- divider step
  assign rem_shift  = {rem, quo[VALUE_BITS-1]};
  assign qbit       = (rem_shift >= eff_radix);
  assign rem_next   = qbit ? DIGIT_W'(rem_shift - eff_radix) : rem_shift[DIGIT_W-1:0];
  assign qnz_next   = qnz | qbit;
  assign digit_done = (state == S_DIV) && (bitcnt == LAST_BIT);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (bitcnt == LAST_BIT && !qnz_next) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_LD;
      end
      S_LD: begin
        if (!out_valid || !out_stall) begin
          state_next = (idx == '0) ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    load     = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_DIV:  ram_we   = digit_done;
      S_RD:   ;
      S_LD:   load     = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      bitcnt <= '0;
      qnz    <= 1'b0;
    end else if (in_accept) begin
      idx    <= '0;
      bitcnt <= '0;
      qnz    <= 1'b0;
    end else if (state == S_DIV) begin
      if (digit_done) begin
        bitcnt <= '0;
        qnz    <= 1'b0;
        if (qnz_next) begin
          idx <= idx + 1'b1;
        end
      end else begin
        bitcnt <= bitcnt + 1'b1;
        qnz    <= qnz_next;
      end
    end else if (load && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      quo <= value;
      rem <= '0;
    end else if (state == S_DIV) begin
      quo <= {quo[VALUE_BITS-2:0], qbit};
      // the remainder starts over for the next digit
      rem <= digit_done ? '0 : rem_next;
    end
  end

  rnd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (rem_next),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit_char <= digit_to_char(ram_rdata);
      last_digit <= (idx == '0);
    end
  end

  // ---------------------------------------------------------------- assertions
  a_digit_below_radix: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, rem_next} < eff_radix))
    else $error("stored digit not below radix");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_DIV) && (bitcnt == '0) && (idx == '0))
    else $error("division did not start cleanly");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (load && idx == '0) |=> (state == S_IDLE) && out_valid && last_digit)
    else $error("last digit did not end the item");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (idx <= AW'(VALUE_BITS - 1)))
    else $error("digit index beyond largest digit count");

  a_no_load_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> !$rose(out_valid))
    else $error("output loaded during division");

endmodule
